/* rtl/ipid_pkg.sv */
// Shared types, widths and constants of the incremental PID controller with stall detection.
package ipid_pkg;

	localparam int DEF_WINDOW_DEPTH = 10;

	localparam int POS_W     = 16;
	localparam int ERR_W     = 17;
	localparam int GAIN_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int DRIVE_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MAC_A_W   = 33;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam int IN_LEAD_LSB   = 16;
	localparam int IN_LSTOP_BIT  = 32;
	localparam int OUT_SAT_BIT   = 32;
	localparam int OUT_STOP_BIT  = 33;

	localparam int FACTOR_SHIFT = 14;
	localparam int DRIVE_SHIFT  = 12;

	localparam logic signed [POS_W-1:0] RST_OFFSET = 16'sd0;
	localparam logic signed [POS_W-1:0] RST_FACTOR = 16'sd16384;
	localparam logic [GAIN_W-1:0]       RST_PROP   = 32'd26214400;
	localparam logic [GAIN_W-1:0]       RST_INTEG  = 32'd26214;
	localparam logic [GAIN_W-1:0]       RST_DERIV  = 32'd0;
	localparam logic [LIMIT_W-1:0]      RST_LIMIT  = 31'd3276800;
	localparam logic [GAIN_W-1:0]       RST_THR    = 32'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOLLOW_MODE    = 3'd0,
		REG_TARGET_OFFSET  = 3'd1,
		REG_FOLLOW_FACTOR  = 3'd2,
		REG_PROP_GAIN      = 3'd3,
		REG_INTEG_GAIN     = 3'd4,
		REG_DERIV_GAIN     = 3'd5,
		REG_DRIVE_LIMIT    = 3'd6,
		REG_STOP_THRESHOLD = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MAC_HOLD  = 3'd0,
		MAC_CLR   = 3'd1,
		MAC_LOAD  = 3'd2,
		MAC_ADD   = 3'd3,
		MAC_SUB   = 3'd4,
		MAC_SCALE = 3'd5
	} mac_op_t;

	typedef struct packed {
		logic             en;
		logic             sat;
		logic [POS_W-1:0] pos;
	} win_push_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic             sat;
		logic [POS_W-1:0] pos;
	} win_elem_t;

endpackage

/* rtl/incremental_pid_with_stall_detect_core.sv */
// Top level of the incremental PID controller with stall detection.
//
// One input transfer on the s_ channel is one control tick; each tick yields
// exactly one result transfer on the m_ channel. The block works on one tick
// at a time and holds s_tready low from acceptance until the result has been
// placed in the output register.
// s_tready rises in the same cycle as m_tvalid. In follower mode with the
// leader not stopped the window walk is skipped. The length of a tick is
// set by the single shared multiplier: the leader product, three gain
// products, one square per window entry, the square of the window sum and
// the scaled threshold go through it one after another.
// The result waits in the output register while m_tready is low; the next
// tick may be accepted and computed meanwhile, and it is held in its last
// step until the earlier result has been taken.
// Configuration writes on cfg_we take effect at once and belong between ticks.
// Reset clears the errors, the drive, the window fill count and the stop
// flag, and loads the register defaults; no clearing pass is needed.
module incremental_pid_with_stall_detect_core import ipid_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// measured_position [15:0], leader_position [31:16], leader_stopped [32]
	input  logic [S_DATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// drive [31:0], saturated [32], stopped [33]
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int SUM_W = POS_W + $clog2(WINDOW_DEPTH);
	localparam int B_W   = (SUM_W > ERR_W + 2) ? SUM_W : ERR_W + 2;
	localparam int P_W   = MAC_A_W + B_W;
	localparam int ACC_W = P_W + 1;
	localparam int U_W   = ACC_W - DRIVE_SHIFT + 1;
	localparam int TS_W  = POS_W + 3;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_TMUL  = 14'h0002,
		ST_TGT   = 14'h0004,
		ST_PMUL  = 14'h0008,
		ST_IMUL  = 14'h0010,
		ST_DMUL  = 14'h0020,
		ST_DWAIT = 14'h0040,
		ST_UPD   = 14'h0080,
		ST_WALK  = 14'h0100,
		ST_SCL   = 14'h0200,
		ST_SQ    = 14'h0400,
		ST_THR   = 14'h0800,
		ST_CMP   = 14'h1000,
		ST_DONE  = 14'h2000
	} state_t;

	state_t                     state_q;

	logic                       follow_q;
	logic signed [POS_W-1:0]    offset_q;
	logic signed [POS_W-1:0]    factor_q;
	logic [GAIN_W-1:0]          prop_q;
	logic [GAIN_W-1:0]          integ_q;
	logic [GAIN_W-1:0]          deriv_q;
	logic [LIMIT_W-1:0]         limit_q;
	logic [GAIN_W-1:0]          thr_q;

	logic signed [POS_W-1:0]    meas_q;
	logic signed [POS_W-1:0]    lead_q;
	logic                       lstop_q;

	logic signed [ERR_W-1:0]    e0_q;
	logic signed [ERR_W-1:0]    e1_q;
	logic signed [ERR_W-1:0]    e2_q;
	logic signed [DRIVE_W-1:0]  drive_q;
	logic                       sat_q;
	logic                       stop_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       allsat_q;

	logic                       m_tvalid_q;
	logic [M_DATA_W-1:0]        m_tdata_q;

	mac_op_t                    mac_op;
	logic signed [MAC_A_W-1:0]  mac_a;
	logic signed [B_W-1:0]      mac_b;
	logic signed [P_W-1:0]      prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_w;

	win_push_t                  push;
	logic                       walk;
	win_elem_t                  elem;

	logic signed [ERR_W:0]      d1;
	logic signed [ERR_W+1:0]    d2;
	logic signed [31:0]         tround;
	logic signed [TS_W-1:0]     tsh;
	logic signed [TS_W-1:0]     tsum;
	logic signed [POS_W-1:0]    tgt;
	logic signed [ERR_W-1:0]    e_new;
	logic signed [U_W-1:0]      u;
	logic signed [U_W-1:0]      lim_pos;
	logic signed [U_W-1:0]      lim_neg;
	logic signed [DRIVE_W-1:0]  drive_new;
	logic                       sat_new;

	ipid_mac #(
		.B_W   (B_W),
		.SCALE (WINDOW_DEPTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (mac_op),
		.a       (mac_a),
		.b       (mac_b),
		.prod_s1 (prod_s1),
		.acc_q   (acc_q)
	);

	ipid_win #(
		.DEPTH (WINDOW_DEPTH)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.walk   (walk),
		.elem   (elem)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign d1 = (ERR_W+1)'(e0_q) - (ERR_W+1)'(e1_q);
	assign d2 = (ERR_W+2)'(e0_q) - ((ERR_W+2)'(e1_q) <<< 1) + (ERR_W+2)'(e2_q);

	// Round the leader product (follow factor in Q2.14) to a whole position, add the offset and saturate.
	assign tround = $signed(prod_s1[31:0]) + 32'sd8192;
	assign tsh    = TS_W'($signed(tround[31:FACTOR_SHIFT]));
	assign tsum   = TS_W'(offset_q) + (follow_q ? tsh : '0);

	always_comb begin
		if (tsum > TS_W'(32767)) begin
			tgt = 16'sh7FFF;
		end else if (tsum < -TS_W'(32768)) begin
			tgt = 16'sh8000;
		end else begin
			tgt = tsum[POS_W-1:0];
		end
	end

	assign e_new = ERR_W'(tgt) - ERR_W'(meas_q);

	assign u       = U_W'($signed(acc_q[ACC_W-1:DRIVE_SHIFT])) + U_W'(drive_q);
	assign lim_pos = U_W'({1'b0, limit_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (u > lim_pos) begin
			drive_new = lim_pos[DRIVE_W-1:0];
			sat_new   = 1'b1;
		end else if (u < lim_neg) begin
			drive_new = lim_neg[DRIVE_W-1:0];
			sat_new   = 1'b1;
		end else begin
			drive_new = u[DRIVE_W-1:0];
			sat_new   = 1'b0;
		end
	end

	assign prod_w = ACC_W'(prod_s1);

	assign push.en  = (state_q == ST_UPD);
	assign push.sat = sat_new;
	assign push.pos = meas_q;
	assign walk     = (state_q == ST_UPD) && (!follow_q || lstop_q);

	always_comb begin
		mac_op = MAC_HOLD;
		mac_a  = '0;
		mac_b  = '0;
		case (state_q)
			ST_TMUL: begin
				mac_a = MAC_A_W'(lead_q);
				mac_b = B_W'(factor_q);
			end
			ST_PMUL: begin
				mac_op = MAC_LOAD;
				mac_a  = MAC_A_W'({1'b0, prop_q});
				mac_b  = B_W'(d1);
			end
			ST_IMUL: begin
				mac_op = MAC_ADD;
				mac_a  = MAC_A_W'({1'b0, integ_q});
				mac_b  = B_W'(e0_q);
			end
			ST_DMUL: begin
				mac_op = MAC_ADD;
				mac_a  = MAC_A_W'({1'b0, deriv_q});
				mac_b  = B_W'(d2);
			end
			ST_UPD: begin
				mac_op = MAC_CLR;
			end
			ST_WALK: begin
				if (elem.valid) begin
					mac_op = MAC_ADD;
					mac_a  = MAC_A_W'($signed(elem.pos));
					mac_b  = B_W'($signed(elem.pos));
				end
			end
			ST_SCL: begin
				mac_op = MAC_SCALE;
			end
			ST_SQ: begin
				mac_op = MAC_SUB;
				mac_a  = MAC_A_W'(sum_q);
				mac_b  = B_W'(sum_q);
			end
			ST_THR: begin
				mac_a = MAC_A_W'({1'b0, thr_q});
				mac_b = B_W'(WINDOW_DEPTH);
			end
			default: begin
				mac_op = MAC_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			follow_q <= 1'b0;
			offset_q <= RST_OFFSET;
			factor_q <= RST_FACTOR;
			prop_q   <= RST_PROP;
			integ_q  <= RST_INTEG;
			deriv_q  <= RST_DERIV;
			limit_q  <= RST_LIMIT;
			thr_q    <= RST_THR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOLLOW_MODE:    follow_q <= cfg_wdata[0];
				REG_TARGET_OFFSET:  offset_q <= $signed(cfg_wdata[POS_W-1:0]);
				REG_FOLLOW_FACTOR:  factor_q <= $signed(cfg_wdata[POS_W-1:0]);
				REG_PROP_GAIN:      prop_q   <= cfg_wdata;
				REG_INTEG_GAIN:     integ_q  <= cfg_wdata;
				REG_DERIV_GAIN:     deriv_q  <= cfg_wdata;
				REG_DRIVE_LIMIT:    limit_q  <= cfg_wdata[LIMIT_W-1:0];
				REG_STOP_THRESHOLD: thr_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			meas_q  <= $signed(s_tdata[POS_W-1:0]);
			lead_q  <= $signed(s_tdata[IN_LEAD_LSB+POS_W-1:IN_LEAD_LSB]);
			lstop_q <= s_tdata[IN_LSTOP_BIT];
		end
		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= M_DATA_W'({stop_q, sat_q, drive_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			e0_q       <= '0;
			e1_q       <= '0;
			e2_q       <= '0;
			drive_q    <= '0;
			sat_q      <= 1'b0;
			stop_q     <= 1'b0;
			sum_q      <= '0;
			allsat_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: begin
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					e2_q    <= e1_q;
					e1_q    <= e0_q;
					e0_q    <= e_new;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= ST_IMUL;
				end
				ST_IMUL: begin
					state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					drive_q  <= drive_new;
					sat_q    <= sat_new;
					sum_q    <= '0;
					allsat_q <= 1'b1;
					state_q  <= walk ? ST_WALK : ST_DONE;
				end
				ST_WALK: begin
					if (elem.valid) begin
						sum_q    <= sum_q + SUM_W'($signed(elem.pos));
						allsat_q <= allsat_q & elem.sat;
						if (elem.last) begin
							state_q <= ST_SCL;
						end
					end
				end
				ST_SCL: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_THR;
				end
				ST_THR: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (allsat_q && (acc_q < prod_w)) begin
						stop_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/ipid_mac.sv */
// Shared signed multiplier with a registered product and an accumulator.
module ipid_mac import ipid_pkg::*; #(
	parameter int B_W   = 19,
	parameter int SCALE = DEF_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mac_op_t                          op,
	input  logic signed [MAC_A_W-1:0]        a,
	input  logic signed [B_W-1:0]            b,
	output logic signed [MAC_A_W+B_W-1:0]    prod_s1,
	output logic signed [MAC_A_W+B_W:0]      acc_q
);

	localparam int P_W   = MAC_A_W + B_W;
	localparam int ACC_W = P_W + 1;

	mac_op_t                  op_s1;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_d;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_comb begin
		case (op_s1)
			MAC_HOLD:  acc_d = acc_q;
			MAC_CLR:   acc_d = '0;
			MAC_LOAD:  acc_d = prod_ext;
			MAC_ADD:   acc_d = acc_q + prod_ext;
			MAC_SUB:   acc_d = acc_q - prod_ext;
			MAC_SCALE: acc_d = acc_q * ACC_W'(SCALE);
			default:   acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MAC_HOLD;
			acc_q <= '0;
		end else begin
			op_s1 <= op;
			acc_q <= acc_d;
		end
	end

endmodule

/* rtl/ipid_win.sv */
// Circular window of positions and saturation flags, with a sequential read walk.
module ipid_win import ipid_pkg::*; #(
	parameter int DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  win_push_t push,
	input  logic      walk,
	output win_elem_t elem
);

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL     = FILL_W'(DEPTH);

	logic [POS_W:0]      mem [DEPTH];
	logic [POS_W:0]      rd_s1;
	logic [IDX_W-1:0]    wr_idx_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [FILL_W-1:0]   fill_q;
	logic                busy_q;
	logic                vld_s1;
	logic                last_s1;
	logic                hit_s1;

	// Entries at or above the fill count were never written and read as zero.
	always_ff @(posedge clk) begin
		if (push.en) begin
			mem[wr_idx_q] <= {push.sat, push.pos};
		end
		rd_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
			busy_q   <= 1'b0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (rd_idx_q == LAST_IDX);
			hit_s1  <= FILL_W'(rd_idx_q) < fill_q;
			if (push.en) begin
				wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
				if (fill_q != FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (walk) begin
				rd_idx_q <= '0;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_idx_q <= '0;
					busy_q   <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	assign elem.valid = vld_s1;
	assign elem.last  = last_s1;
	assign elem.sat   = hit_s1 & rd_s1[POS_W];
	assign elem.pos   = hit_s1 ? rd_s1[POS_W-1:0] : '0;

endmodule

/* rtl/ipid_chk.sv */
// Port-level checker of the PID controller core and its bind to the top level.
module ipid_chk import ipid_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	logic seen_stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_stop_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[OUT_STOP_BIT]) begin
			seen_stop_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed or vanished while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted again in the cycle after a transfer.");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("Result appeared while the block was idle.");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_stop_q |-> m_tdata[OUT_STOP_BIT])
		else $error("Stop flag cleared after it was reported set.");

endmodule

bind incremental_pid_with_stall_detect_core ipid_chk u_ipid_chk (.*);
